@@ rtl/bgpfsm_pkg.sv @@
package bgpfsm_pkg;

	// Event codes carried in the kind field
	localparam logic [3:0] EV_START     = 4'd0;
	localparam logic [3:0] EV_STOP      = 4'd1;
	localparam logic [3:0] EV_TCP_UP    = 4'd2;
	localparam logic [3:0] EV_TCP_CLOSE = 4'd3;
	localparam logic [3:0] EV_FATAL     = 4'd4;
	localparam logic [3:0] EV_RETRANS   = 4'd5;
	localparam logic [3:0] EV_RETRY_TMR = 4'd6;
	localparam logic [3:0] EV_HOLD_TMR  = 4'd7;
	localparam logic [3:0] EV_KA_TMR    = 4'd8;
	localparam logic [3:0] EV_OPEN_RX   = 4'd9;
	localparam logic [3:0] EV_KA_RX     = 4'd10;
	localparam logic [3:0] EV_UPDATE_RX = 4'd11;
	localparam logic [3:0] EV_NOTIFY_RX = 4'd12;

	// Actions
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_CONNECT   = 3'd1;
	localparam logic [2:0] ACT_OPEN      = 3'd2;
	localparam logic [2:0] ACT_KEEPALIVE = 3'd3;
	localparam logic [2:0] ACT_NOTIFY    = 3'd4;

	// Notification error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_HEADER = 3'd1;
	localparam logic [2:0] ERR_OPEN   = 3'd2;
	localparam logic [2:0] ERR_FSM    = 3'd5;

	// Received open checks
	localparam logic [7:0] OPEN_TYPE_CODE   = 8'd1;
	localparam logic [7:0] EXPECTED_VERSION = 8'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_VERSION   = 2'd0;
	localparam logic [1:0] REG_AS        = 2'd1;
	localparam logic [1:0] REG_HOLD_TIME = 2'd2;
	localparam logic [1:0] REG_ROUTER_ID = 2'd3;

	// Register reset values
	localparam logic [7:0]  RST_VERSION   = 8'd4;
	localparam logic [15:0] RST_AS        = 16'd0;
	localparam logic [15:0] RST_HOLD_TIME = 16'd90;
	localparam logic [31:0] RST_ROUTER_ID = 32'd0;

endpackage

@@ rtl/bgp_peer_session_fsm.sv @@
// An accepted word passes through the input register and then the output register.
// One event word per cycle unless the output stalls; the input register advances
// whenever the output register is empty or its word is taken in the same cycle.
// The session state register, the input register and the output register form the loop.
// Reset (arst_n low, asynchronous): session idle, both registers empty,
// configuration back to version 4, AS 0, hold time 90, router ID 0.
module bgp_peer_session_fsm
	import bgpfsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,

	// Event word
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  kind,
	input  logic [7:0]  open_type,
	input  logic [7:0]  open_version,

	// Result word
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  next_state,
	output logic [2:0]  action,
	output logic [2:0]  notify_code,
	output logic        rejected,
	output logic [7:0]  out_version,
	output logic [15:0] out_as,
	output logic [15:0] out_hold_time,
	output logic [31:0] out_router_id
);

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_CONNECT     = 3'd1,
		ST_ACTIVE      = 3'd2,
		ST_OPENSENT    = 3'd3,
		ST_OPENCONFIRM = 3'd4,
		ST_ESTABLISHED = 3'd5
	} state_t;

	// Session state, committed when a word leaves the input register
	state_t state_q;

	// Configuration registers
	logic [7:0]  version_q;
	logic [15:0] as_q;
	logic [15:0] hold_time_q;
	logic [31:0] router_id_q;

	// Input register
	logic       valid_s1;
	logic [3:0] kind_s1;
	logic [7:0] open_type_s1;
	logic [7:0] open_version_s1;

	// Output register
	logic        valid_s2;
	state_t      ns_s2;
	logic [2:0]  act_s2;
	logic [2:0]  code_s2;
	logic        rej_s2;
	logic [7:0]  version_s2;
	logic [15:0] as_s2;
	logic [15:0] hold_time_s2;
	logic [31:0] router_id_s2;

	// Next-state decode
	state_t     ns;
	logic [2:0] act;
	logic [2:0] code;
	logic       rej;
	logic       conn_wait;
	logic       up;
	logic       advance;

	// Move the held event into the output register when it is free or being emptied
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign conn_wait = state_q inside {ST_CONNECT, ST_ACTIVE};
	assign up        = state_q inside {ST_OPENCONFIRM, ST_ESTABLISHED};

	always_comb begin
		ns   = state_q;
		act  = ACT_NONE;
		code = ERR_NONE;
		rej  = 1'b0;
		case (kind_s1)
			EV_START: begin
				if (state_q == ST_IDLE) begin
					ns  = ST_CONNECT;
					act = ACT_CONNECT;
				end
			end
			EV_STOP, EV_FATAL, EV_HOLD_TMR, EV_NOTIFY_RX: begin
				ns = ST_IDLE;
			end
			EV_TCP_UP: begin
				if (conn_wait) begin
					ns  = ST_OPENSENT;
					act = ACT_OPEN;
				end else if (up) begin
					// transport came up again on a live session: protocol error
					ns   = ST_IDLE;
					act  = ACT_NOTIFY;
					code = ERR_FSM;
				end else begin
					ns = ST_IDLE;
				end
			end
			EV_TCP_CLOSE: begin
				ns = (state_q == ST_OPENSENT) ? ST_ACTIVE : ST_IDLE;
			end
			EV_RETRANS: begin
				ns = conn_wait ? ST_ACTIVE : ST_IDLE;
			end
			EV_RETRY_TMR: begin
				if (conn_wait) begin
					ns  = ST_CONNECT;
					act = ACT_CONNECT;
				end else begin
					ns = ST_IDLE;
				end
			end
			EV_KA_TMR: begin
				if (up) begin
					act = ACT_KEEPALIVE;
				end else begin
					ns = ST_IDLE;
				end
			end
			EV_OPEN_RX: begin
				if (state_q == ST_OPENSENT) begin
					// type check takes precedence over the version check
					if (open_type_s1 != OPEN_TYPE_CODE) begin
						ns   = ST_IDLE;
						act  = ACT_NOTIFY;
						code = ERR_HEADER;
						rej  = 1'b1;
					end else if (open_version_s1 != EXPECTED_VERSION) begin
						ns   = ST_IDLE;
						act  = ACT_NOTIFY;
						code = ERR_OPEN;
						rej  = 1'b1;
					end else begin
						ns  = ST_OPENCONFIRM;
						act = ACT_KEEPALIVE;
					end
				end else if (state_q != ST_IDLE) begin
					ns = ST_IDLE;
				end
			end
			EV_KA_RX: begin
				if (state_q == ST_OPENCONFIRM) begin
					ns = ST_ESTABLISHED;
				end else if (conn_wait || state_q == ST_OPENSENT) begin
					ns = ST_IDLE;
				end
			end
			EV_UPDATE_RX: begin
				if (conn_wait || state_q == ST_OPENSENT || state_q == ST_OPENCONFIRM) begin
					ns = ST_IDLE;
				end
			end
			default: begin
				// unused event codes: hold state, no action
				ns = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			version_q       <= RST_VERSION;
			as_q            <= RST_AS;
			hold_time_q     <= RST_HOLD_TIME;
			router_id_q     <= RST_ROUTER_ID;
			valid_s1        <= 1'b0;
			kind_s1         <= '0;
			open_type_s1    <= '0;
			open_version_s1 <= '0;
			valid_s2        <= 1'b0;
			ns_s2           <= ST_IDLE;
			act_s2          <= ACT_NONE;
			code_s2         <= ERR_NONE;
			rej_s2          <= 1'b0;
			version_s2      <= '0;
			as_s2           <= '0;
			hold_time_s2    <= '0;
			router_id_s2    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VERSION:   version_q   <= cfg_wdata[7:0];
					REG_AS:        as_q        <= cfg_wdata[15:0];
					REG_HOLD_TIME: hold_time_q <= cfg_wdata[15:0];
					REG_ROUTER_ID: router_id_q <= cfg_wdata;
					default:       version_q   <= version_q;
				endcase
			end

			// input register: load on accept, drop once the word moves on
			if (in_valid && in_ready) begin
				valid_s1        <= 1'b1;
				kind_s1         <= kind;
				open_type_s1    <= open_type;
				open_version_s1 <= open_version;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			// output register and state commit
			if (advance) begin
				state_q  <= ns;
				valid_s2 <= 1'b1;
				ns_s2    <= ns;
				act_s2   <= act;
				code_s2  <= code;
				rej_s2   <= rej;
				if (act == ACT_OPEN) begin
					version_s2   <= version_q;
					as_s2        <= as_q;
					hold_time_s2 <= hold_time_q;
					router_id_s2 <= router_id_q;
				end else begin
					version_s2   <= '0;
					as_s2        <= '0;
					hold_time_s2 <= '0;
					router_id_s2 <= '0;
				end
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign next_state    = ns_s2;
	assign action        = act_s2;
	assign notify_code   = code_s2;
	assign rejected      = rej_s2;
	assign out_version   = version_s2;
	assign out_as        = as_s2;
	assign out_hold_time = hold_time_s2;
	assign out_router_id = router_id_s2;

`ifndef ASSERT_OFF
	// the committed state always matches the last word loaded into the output register
	a_state_commit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> state_q == ns_s2)
		else $error("session state differs from last reported next state");

	// a rejected open always drops to idle with a notification
	a_reject_notify: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rej_s2 |-> act_s2 == ACT_NOTIFY && ns_s2 == ST_IDLE
			&& (code_s2 == ERR_HEADER || code_s2 == ERR_OPEN))
		else $error("reject without notification to idle");

	// error code present exactly when a notification is sent
	a_code_notify: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (code_s2 != ERR_NONE) == (act_s2 == ACT_NOTIFY))
		else $error("notification code and action disagree");

	// open fields stay zero unless an open is sent
	a_open_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && act_s2 != ACT_OPEN |-> version_s2 == '0 && as_s2 == '0
			&& hold_time_s2 == '0 && router_id_s2 == '0)
		else $error("open fields set without send open");

	// a word waiting at the output is never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(act_s2) && $stable(ns_s2))
		else $error("stalled result word changed");
`endif

endmodule

@@ dv/tb_bgp_peer_session_fsm.sv @@
`timescale 1ns / 1ps

module tb_bgp_peer_session_fsm;
	import bgpfsm_pkg::*;

	// Session states as the block reports them on next_state
	typedef enum logic [2:0] {
		SS_IDLE,
		SS_CONNECT,
		SS_ACTIVE,
		SS_OPENSENT,
		SS_OPENCONFIRM,
		SS_ESTABLISHED
	} peer_state_t;

	// Event codes the block treats as no-ops
	localparam logic [3:0] EV_FIRST_UNUSED = 4'd13;
	localparam logic [3:0] EV_LAST_UNUSED  = 4'd15;

	localparam int unsigned WORDS_PER_PHASE = 300;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] otype;
		logic [7:0] over;
	} session_event_t;

	typedef struct packed {
		peer_state_t nxt;
		logic [2:0]  act;
		logic [2:0]  code;
		logic        rej;
		logic [7:0]  ver;
		logic [15:0] asn;
		logic [15:0] hold;
		logic [31:0] rid;
	} session_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  kind = '0;
	logic [7:0]  open_type = '0;
	logic [7:0]  open_version = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  next_state;
	logic [2:0]  action;
	logic [2:0]  notify_code;
	logic        rejected;
	logic [7:0]  out_version;
	logic [15:0] out_as;
	logic [15:0] out_hold_time;
	logic [31:0] out_router_id;

	bgp_peer_session_fsm dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.open_type     (open_type),
		.open_version  (open_version),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.next_state    (next_state),
		.action        (action),
		.notify_code   (notify_code),
		.rejected      (rejected),
		.out_version   (out_version),
		.out_as        (out_as),
		.out_hold_time (out_hold_time),
		.out_router_id (out_router_id)
	);

	// Our own copy of the session and of the open fields the block advertises
	peer_state_t peer_state = SS_IDLE;
	logic [7:0]  own_version = RST_VERSION;
	logic [15:0] own_as = RST_AS;
	logic [15:0] own_hold = RST_HOLD_TIME;
	logic [31:0] own_router_id = RST_ROUTER_ID;

	session_event_t  pending_events[$];
	session_result_t expected_results[$];

	// Set while the driver has a word on the bus that is not yet taken
	bit          holding_word = 1'b0;
	// Suppress idling on both sides for a whole phase
	bit          quiet = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;

	int unsigned mismatches = 0;
	int unsigned words_queued = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned sessions_up = 0;
	int unsigned opens_rejected = 0;
	int unsigned settings_used = 1;

	initial begin
		forever #10 clk = ~clk;
	end

	// Hold reset low from time zero, then release it for good
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: far beyond the slowest legal run, so only a hang trips it
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Mostly back-to-back, some short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Advance our copy of the session by one event and return the word the
	// block should emit for it.
	function automatic session_result_t advance_session(session_event_t ev);
		session_result_t r;
		peer_state_t     s;
		logic            conn_wait;
		logic            up;
		s = peer_state;
		r = '0;
		r.nxt = s;
		conn_wait = (s == SS_CONNECT) || (s == SS_ACTIVE);
		up = (s == SS_OPENCONFIRM) || (s == SS_ESTABLISHED);
		case (ev.kind)
		EV_START: begin
			if (s == SS_IDLE) begin
				r.nxt = SS_CONNECT;
				r.act = ACT_CONNECT;
			end
		end
		EV_STOP, EV_FATAL, EV_HOLD_TMR: r.nxt = SS_IDLE;
		EV_TCP_UP: begin
			if (conn_wait) begin
				r.nxt = SS_OPENSENT;
				r.act = ACT_OPEN;
			end else if (up) begin
				// transport came up again under a live session
				r.nxt = SS_IDLE;
				r.act = ACT_NOTIFY;
				r.code = ERR_FSM;
			end else begin
				r.nxt = SS_IDLE;
			end
		end
		EV_TCP_CLOSE: r.nxt = (s == SS_OPENSENT) ? SS_ACTIVE : SS_IDLE;
		EV_RETRANS: r.nxt = conn_wait ? SS_ACTIVE : SS_IDLE;
		EV_RETRY_TMR: begin
			if (conn_wait) begin
				r.nxt = SS_CONNECT;
				r.act = ACT_CONNECT;
			end else begin
				r.nxt = SS_IDLE;
			end
		end
		EV_KA_TMR: begin
			if (up)
				r.act = ACT_KEEPALIVE;
			else
				r.nxt = SS_IDLE;
		end
		EV_OPEN_RX: begin
			if (s == SS_OPENSENT) begin
				// type is checked ahead of version
				if (ev.otype != OPEN_TYPE_CODE) begin
					r.nxt = SS_IDLE;
					r.act = ACT_NOTIFY;
					r.code = ERR_HEADER;
					r.rej = 1'b1;
				end else if (ev.over != EXPECTED_VERSION) begin
					r.nxt = SS_IDLE;
					r.act = ACT_NOTIFY;
					r.code = ERR_OPEN;
					r.rej = 1'b1;
				end else begin
					r.nxt = SS_OPENCONFIRM;
					r.act = ACT_KEEPALIVE;
				end
			end else if (s != SS_IDLE) begin
				r.nxt = SS_IDLE;
			end
		end
		EV_KA_RX: begin
			if (s == SS_OPENCONFIRM)
				r.nxt = SS_ESTABLISHED;
			else if (conn_wait || s == SS_OPENSENT)
				r.nxt = SS_IDLE;
		end
		EV_UPDATE_RX: begin
			if (conn_wait || s == SS_OPENSENT || s == SS_OPENCONFIRM)
				r.nxt = SS_IDLE;
		end
		EV_NOTIFY_RX: r.nxt = SS_IDLE;
		default: ;
		endcase
		if (r.act == ACT_OPEN) begin
			r.ver = own_version;
			r.asn = own_as;
			r.hold = own_hold;
			r.rid = own_router_id;
		end
		if (r.nxt == SS_ESTABLISHED && s != SS_ESTABLISHED)
			sessions_up++;
		if (r.rej)
			opens_rejected++;
		peer_state = r.nxt;
		return r;
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	// Driver: present the next pending word, predict it when it is taken
	always @(posedge clk or negedge arst_n) begin : drive
		session_event_t word;
		if (!arst_n) begin
			in_valid <= 1'b0;
			holding_word = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				word.kind = kind;
				word.otype = open_type;
				word.over = open_version;
				expected_results.push_back(advance_session(word));
				words_sent++;
				holding_word = 1'b0;
			end
			// while a word waits, valid and payload hold untouched
			if (!holding_word) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					word = pending_events.pop_front();
					kind <= word.kind;
					open_type <= word.otype;
					open_version <= word.over;
					in_valid <= 1'b1;
					holding_word = 1'b1;
					send_gap = quiet ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest prediction, and
	// throttle out_ready with random stalls.
	always @(posedge clk or negedge arst_n) begin : watch
		session_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word arrived with no event outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("next_state", want.nxt, next_state);
					check_field("action", want.act, action);
					check_field("notify_code", want.code, notify_code);
					check_field("rejected", want.rej, rejected);
					check_field("out_version", want.ver, out_version);
					check_field("out_as", want.asn, out_as);
					check_field("out_hold_time", want.hold, out_hold_time);
					check_field("out_router_id", want.rid, out_router_id);
					results_seen++;
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = quiet ? 0 : pick_gap();
			end
		end
	end

	task automatic queue_word(logic [3:0] k, logic [7:0] t, logic [7:0] v);
		session_event_t word;
		word.kind = k;
		word.otype = t;
		word.over = v;
		pending_events.push_back(word);
		words_queued++;
	endtask

	// Event with random open bytes; they only matter for an open in open-sent
	function automatic session_event_t with_noise(logic [3:0] k);
		session_event_t word;
		word.kind = k;
		word.otype = 8'($urandom);
		word.over = 8'($urandom);
		return word;
	endfunction

	// Write all four registers on consecutive edges; only while idle
	task automatic write_registers(logic [31:0] ver, logic [31:0] asn, logic [31:0] hold,
			logic [31:0] rid);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_VERSION;
		cfg_wdata <= ver;
		own_version = ver[7:0];
		@(posedge clk);
		cfg_index <= REG_AS;
		cfg_wdata <= asn;
		own_as = asn[15:0];
		@(posedge clk);
		cfg_index <= REG_HOLD_TIME;
		cfg_wdata <= hold;
		own_hold = hold[15:0];
		@(posedge clk);
		cfg_index <= REG_ROUTER_ID;
		cfg_wdata <= rid;
		own_router_id = rid;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Hold the sender until every predicted result has been taken
	task automatic wait_drained();
		while (pending_events.size() != 0 || holding_word || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A well-formed session walk with random content; a broken one has one
	// step swapped for an arbitrary event.
	task automatic queue_session(bit broken);
		session_event_t steps[$];
		session_event_t word;
		int unsigned    idx;
		logic [7:0]     t;
		logic [7:0]     v;
		if ($urandom_range(0, 1))
			steps.push_back(with_noise(EV_STOP));
		steps.push_back(with_noise(EV_START));
		repeat ($urandom_range(0, 2))
			steps.push_back(with_noise($urandom_range(0, 1) ? EV_RETRY_TMR : EV_RETRANS));
		steps.push_back(with_noise(EV_TCP_UP));
		if ($urandom_range(0, 6) == 0) begin
			steps.push_back(with_noise(EV_TCP_CLOSE));
			steps.push_back(with_noise(EV_TCP_UP));
		end
		if ($urandom_range(0, 7) == 0) begin
			// malformed open: wrong type, or right type with a wrong version
			if ($urandom_range(0, 1)) begin
				do t = 8'($urandom); while (t == OPEN_TYPE_CODE);
				v = 8'($urandom);
			end else begin
				t = OPEN_TYPE_CODE;
				do v = 8'($urandom); while (v == EXPECTED_VERSION);
			end
			word.kind = EV_OPEN_RX;
			word.otype = t;
			word.over = v;
			steps.push_back(word);
		end else begin
			word.kind = EV_OPEN_RX;
			word.otype = OPEN_TYPE_CODE;
			word.over = EXPECTED_VERSION;
			steps.push_back(word);
			if ($urandom_range(0, 2) == 0)
				steps.push_back(with_noise(EV_KA_TMR));
			steps.push_back(with_noise(EV_KA_RX));
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 4))
				0: steps.push_back(with_noise(EV_KA_TMR));
				1: steps.push_back(with_noise(EV_KA_RX));
				2: steps.push_back(with_noise(EV_UPDATE_RX));
				3: steps.push_back(with_noise(EV_START));
				default: steps.push_back(with_noise(
					4'($urandom_range(EV_FIRST_UNUSED, EV_LAST_UNUSED))));
				endcase
			end
			// tear down with anything at all
			steps.push_back(with_noise(4'($urandom)));
		end
		if (broken) begin
			idx = $urandom_range(0, steps.size() - 1);
			steps[idx] = with_noise(4'($urandom));
		end
		foreach (steps[i])
			queue_word(steps[i].kind, steps[i].otype, steps[i].over);
	endtask

	initial begin : stimulus
		int unsigned pick;
		int unsigned target;
		repeat (4) @(posedge clk);

		// Directed walk with reset register values
		queue_word(EV_OPEN_RX, 8'hFF, 8'hFF);        // open ignored in idle
		queue_word(EV_KA_RX, 8'h00, 8'h00);
		queue_word(EV_UPDATE_RX, 8'hFF, 8'h00);
		queue_word(EV_FIRST_UNUSED, 8'h00, 8'hFF);   // unused code, no change
		queue_word(EV_START, 8'h00, 8'h00);
		queue_word(EV_START, 8'h00, 8'h00);          // start outside idle
		queue_word(EV_RETRY_TMR, 8'h00, 8'h00);      // retry in connect
		queue_word(EV_RETRANS, 8'h00, 8'h00);
		queue_word(EV_RETRY_TMR, 8'h00, 8'h00);      // retry in active
		queue_word(EV_TCP_UP, 8'h00, 8'h00);         // open with reset fields
		queue_word(EV_OPEN_RX, 8'h00, 8'h00);        // both checks fail
		queue_word(EV_START, 8'h00, 8'h00);
		queue_word(EV_TCP_UP, 8'h00, 8'h00);
		queue_word(EV_OPEN_RX, OPEN_TYPE_CODE, 8'hFF); // version only
		queue_word(EV_START, 8'h00, 8'h00);
		queue_word(EV_TCP_UP, 8'h00, 8'h00);
		queue_word(EV_TCP_CLOSE, 8'h00, 8'h00);      // back to active
		queue_word(EV_TCP_UP, 8'h00, 8'h00);
		queue_word(EV_OPEN_RX, OPEN_TYPE_CODE, EXPECTED_VERSION);
		queue_word(EV_KA_TMR, 8'h00, 8'h00);
		queue_word(EV_KA_RX, 8'h00, 8'h00);
		queue_word(EV_UPDATE_RX, 8'h00, 8'h00);      // no effect once up
		queue_word(EV_KA_RX, 8'h00, 8'h00);
		queue_word(EV_LAST_UNUSED, 8'hFF, 8'hFF);
		queue_word(EV_TCP_UP, 8'h00, 8'h00);         // fsm error while up
		wait_drained();

		// Random phases, each under its own register setting; the first two
		// are the extremes, and the all-ones one runs with no idling at all.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
			0: write_registers('0, '0, '0, '0);
			1: write_registers('1, '1, '1, '1);
			default: write_registers($urandom, $urandom, $urandom, $urandom);
			endcase
			quiet = (phase == 1);
			target = words_queued + WORDS_PER_PHASE;
			while (words_queued < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					repeat ($urandom_range(1, 4))
						queue_word(4'($urandom), 8'($urandom), 8'($urandom));
				end else begin
					queue_session(pick < 40);
				end
			end
			wait_drained();
		end

		$display("Ran %0d event words under %0d register settings, %0d results compared.",
			words_sent, settings_used, results_seen);
		$display("Sessions reached established %0d times; %0d received opens rejected.",
			sessions_up, opens_rejected);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
